@@ rtl/insph_pkg.sv @@
// Package for the in-sphere predicate: widths and the coordinate unpack helper.
// No dependencies.
package insph_pkg;
   localparam int COORD_BITS = 16;
   localparam int PT_BITS    = 48;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * DIFF_BITS;
   localparam int LIFT_BITS  = PROD_BITS + 2;
   localparam int M2_BITS    = PROD_BITS + 1;
   localparam int DP_BITS    = M2_BITS + DIFF_BITS;
   localparam int M3_BITS    = DP_BITS + 2;
   localparam int TERM_BITS  = M3_BITS + LIFT_BITS + 1;
   localparam int ACC_BITS   = TERM_BITS + 2;
   localparam int M3_SPLIT   = M3_BITS / 2;
   localparam int LIFT_SPLIT = LIFT_BITS / 2;
   localparam int PP_BITS    = M3_BITS - M3_SPLIT + LIFT_BITS - LIFT_SPLIT + 2;
   localparam int ZB         = (PT_BITS - 2 * COORD_BITS < COORD_BITS) ?
                               PT_BITS - 2 * COORD_BITS : COORD_BITS;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;

   function automatic coord_type coord_of(input logic [PT_BITS-1:0] p, input int slot);
      coord_type c;
      c = '0;
      if (slot < 2) begin
         c = p[slot*COORD_BITS +: COORD_BITS];
      end else begin
         c[ZB-1:0] = p[2*COORD_BITS +: ZB];
      end
      return c;
   endfunction
endpackage

@@ rtl/insphere_predicate_core.sv @@
// In-sphere predicate, top level: seven-stage pipeline with valid per stage.
// Throughput one beat per cycle unless rsp_stall backs up the pipe; a stage
// advances when the next stage is empty or moving. Synchronous active-high
// reset clears the valid bits only; datapath registers are not reset.
// Depends on insph_pkg.
module insphere_predicate_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [insph_pkg::PT_BITS-1:0] req_face_a,
   input  logic [insph_pkg::PT_BITS-1:0] req_face_b,
   input  logic [insph_pkg::PT_BITS-1:0] req_face_c,
   input  logic [insph_pkg::PT_BITS-1:0] req_apex_point,
   input  logic [insph_pkg::PT_BITS-1:0] req_query_point,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_sphere_ok
);
   import insph_pkg::*;

   localparam int NS = 7;
   logic [NS-1:0] vld_ff;
   logic [NS-1:0] adv;

   always_comb begin
      adv[NS-1] = !vld_ff[NS-1] || !rsp_stall;
      for (int s = NS - 2; s >= 0; s--) begin
         adv[s] = !vld_ff[s] || adv[s+1];
      end
   end
   assign req_stall     = !adv[0];
   assign rsp_valid     = vld_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) vld_ff[0] <= req_valid;
         for (int s = 1; s < NS; s++) begin
            if (adv[s]) vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   // stage 1: differences
   diff_type d_ff [4][3];
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         for (int i = 0; i < 4; i++) begin
            for (int k = 0; k < 3; k++) begin
               logic [PT_BITS-1:0] p;
               p = (i == 0) ? req_face_a : (i == 1) ? req_face_b :
                   (i == 2) ? req_face_c : req_apex_point;
               d_ff[i][k] <= DIFF_BITS'(coord_of(p, k)) -
                             DIFF_BITS'(coord_of(req_query_point, k));
            end
         end
      end
   end

   // stage 2: squares and 2x2 products
   logic signed [PROD_BITS-1:0] sq_ff [4][3];
   logic signed [PROD_BITS-1:0] pa_ff [6][3];
   logic signed [PROD_BITS-1:0] pb_ff [6][3];
   diff_type d2_ff [4][3];
   // row pairs: (0,1)(0,2)(0,3)(1,2)(1,3)(2,3); column pairs (1,2)(0,2)(0,1)
   localparam int RA [6] = '{0, 0, 0, 1, 1, 2};
   localparam int RB [6] = '{1, 2, 3, 2, 3, 3};
   localparam int CA [3] = '{1, 0, 0};
   localparam int CB [3] = '{2, 2, 1};
   always_ff @(posedge clock) begin
      if (adv[1]) begin
         d2_ff <= d_ff;
         for (int i = 0; i < 4; i++) begin
            for (int k = 0; k < 3; k++) sq_ff[i][k] <= d_ff[i][k] * d_ff[i][k];
         end
         for (int p = 0; p < 6; p++) begin
            for (int c = 0; c < 3; c++) begin
               pa_ff[p][c] <= d_ff[RA[p]][CA[c]] * d_ff[RB[p]][CB[c]];
               pb_ff[p][c] <= d_ff[RA[p]][CB[c]] * d_ff[RB[p]][CA[c]];
            end
         end
      end
   end

   // stage 3: 2x2 minors, lifts, minor-by-row products
   logic [LIFT_BITS-1:0]         lift_ff [4];
   logic signed [DP_BITS-1:0]    dp_ff [4][3];
   // minor j uses rows excluding j; r0 = first row, pair = the other two
   localparam int R0 [4] = '{1, 0, 0, 0};
   localparam int PR [4] = '{5, 5, 4, 3};
   always_ff @(posedge clock) begin
      if (adv[2]) begin
         for (int i = 0; i < 4; i++) begin
            lift_ff[i] <= LIFT_BITS'(sq_ff[i][0]) + LIFT_BITS'(sq_ff[i][1]) +
                          LIFT_BITS'(sq_ff[i][2]);
         end
         for (int j = 0; j < 4; j++) begin
            for (int c = 0; c < 3; c++) begin
               logic signed [M2_BITS-1:0] m2;
               m2 = M2_BITS'(pa_ff[PR[j]][c]) - M2_BITS'(pb_ff[PR[j]][c]);
               dp_ff[j][c] <= m2 * d2_ff[R0[j]][c];
            end
         end
      end
   end

   // stage 4: 3x3 minors
   logic signed [M3_BITS-1:0]   m3_ff [4];
   logic [LIFT_BITS-1:0]        lift2_ff [4];
   always_ff @(posedge clock) begin
      if (adv[3]) begin
         lift2_ff <= lift_ff;
         for (int j = 0; j < 4; j++) begin
            m3_ff[j] <= M3_BITS'(dp_ff[j][0]) - M3_BITS'(dp_ff[j][1]) +
                        M3_BITS'(dp_ff[j][2]);
         end
      end
   end

   // stage 5: split minor-by-lift products into halves
   logic signed [PP_BITS-1:0] pp_ff [4][4];
   always_ff @(posedge clock) begin
      if (adv[4]) begin
         for (int j = 0; j < 4; j++) begin
            logic signed [M3_BITS-M3_SPLIT-1:0]   mh;
            logic signed [M3_SPLIT:0]             ml;
            logic signed [LIFT_BITS-LIFT_SPLIT:0] lh;
            logic signed [LIFT_SPLIT:0]           ll;
            mh = m3_ff[j][M3_BITS-1:M3_SPLIT];
            ml = {1'b0, m3_ff[j][M3_SPLIT-1:0]};
            lh = {1'b0, lift2_ff[j][LIFT_BITS-1:LIFT_SPLIT]};
            ll = {1'b0, lift2_ff[j][LIFT_SPLIT-1:0]};
            pp_ff[j][0] <= mh * lh;
            pp_ff[j][1] <= mh * ll;
            pp_ff[j][2] <= ml * lh;
            pp_ff[j][3] <= ml * ll;
         end
      end
   end

   // stage 6: recombine partial products
   logic signed [TERM_BITS-1:0] term_ff [4];
   always_ff @(posedge clock) begin
      if (adv[5]) begin
         for (int j = 0; j < 4; j++) begin
            term_ff[j] <= (TERM_BITS'(pp_ff[j][0]) <<< (M3_SPLIT + LIFT_SPLIT)) +
                          (TERM_BITS'(pp_ff[j][1]) <<< M3_SPLIT) +
                          (TERM_BITS'(pp_ff[j][2]) <<< LIFT_SPLIT) +
                          TERM_BITS'(pp_ff[j][3]);
         end
      end
   end

   // stage 7: signed sum and sign
   logic ok_ff;
   always_ff @(posedge clock) begin
      if (adv[6]) begin
         logic signed [ACC_BITS-1:0] acc;
         acc = ACC_BITS'(term_ff[1]) + ACC_BITS'(term_ff[3]) -
               ACC_BITS'(term_ff[0]) - ACC_BITS'(term_ff[2]);
         ok_ff <= !acc[ACC_BITS-1];
      end
   end
   assign rsp_sphere_ok = ok_ff;

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sphere_ok))
      else $error("result changed under stall");
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&vld_ff) && rsp_stall)
      else $error("input stalled with room in pipe");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_stall |=> vld_ff[0])
      else $error("accepted beat lost");
endmodule
